FILE: design/heightmap_palette_colouriser_assert.svh
// Assertion macros shared by the colouriser RTL.
`ifndef HEIGHTMAP_PALETTE_COLOURISER_ASSERT_SVH
`define HEIGHTMAP_PALETTE_COLOURISER_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define HPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked only out of reset.
`define HPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/hpc_pkg.sv
package hpc_pkg;

    // Operation codes carried with each request.
    typedef enum logic [1:0] {
        OP_SCAN  = 2'd0,
        OP_MAP   = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    localparam int T_BITS    = 8;   // interpolation weight bits
    localparam int SEG_BITS  = 3;   // ramp segment index bits
    localparam int QUOT_BITS = T_BITS + SEG_BITS;
    localparam int SCALE_MUL = 5;   // 1280 = 5 << T_BITS
    localparam int CHAN_BITS = 8;

    typedef logic [QUOT_BITS-1:0]   t_quot;
    typedef logic [3*CHAN_BITS-1:0] t_rgb;   // {blue, green, red}

    // Ramp black, blue, cyan, green, yellow, red. Every ramp point channel is
    // either 0 or 255, so each blended channel is 0, 255, t or 255 - t.
    function automatic t_rgb ramp_colour(input t_quot q);
        logic [SEG_BITS-1:0]  seg;
        logic [CHAN_BITS-1:0] t;
        logic [CHAN_BITS-1:0] up;
        logic [CHAN_BITS-1:0] dn;
        logic [CHAN_BITS-1:0] lo;
        logic [CHAN_BITS-1:0] hi;
        t_rgb                 c;
        seg = q[QUOT_BITS-1:T_BITS];
        t   = q[T_BITS-1:0];
        up  = t;
        dn  = ~t;
        lo  = '0;
        hi  = '1;
        unique case (seg)
            3'd0:    c = {up, lo, lo};
            3'd1:    c = {hi, up, lo};
            3'd2:    c = {dn, hi, lo};
            3'd3:    c = {lo, hi, up};
            default: c = {lo, dn, hi};
        endcase
        return c;
    endfunction

endpackage

FILE: design/heightmap_palette_colouriser.sv
// Flow: a map request passes a set-up state, 11 divider steps and an output load;
// an empty or flat range goes straight to the output load. Throughput: a map request
// holds off further requests until its colour is in the output register, as the
// restoring divider is shared (one quotient bit per cycle), and longer while the colour
// output is stalled; scan, clear and unused requests are taken one per cycle when idle.
// Reset: synchronous, active low; idle, output empty, range empty (min all ones).
`include "heightmap_palette_colouriser_assert.svh"

module heightmap_palette_colouriser
    import hpc_pkg::*;
#(
    parameter int HEIGHT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    // Colour stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic [0:0]  m_axis_tuser    // [0] flat
);

    // The numerator (h - min) * 1280 needs HEIGHT_BITS + 11 bits, and the
    // divisor, pre-shifted to the weight of the top quotient bit, the same.
    localparam int NUM_W = HEIGHT_BITS + QUOT_BITS;
    localparam int CNT_W = $clog2(QUOT_BITS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUOT_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

    t_state                 r_state;
    logic [HEIGHT_BITS-1:0] r_lo;
    logic [HEIGHT_BITS-1:0] r_hi;
    logic [HEIGHT_BITS-1:0] r_h;       // clamped sample of the current map
    logic                   r_flat;
    logic [HEIGHT_BITS:0]   r_range;
    logic [NUM_W-1:0]       r_num;     // running remainder
    logic [NUM_W-1:0]       r_den;     // divisor aligned to the current bit
    t_quot                  r_quot;
    logic [CNT_W-1:0]       r_step;
    logic                   r_out_valid;
    t_rgb                   r_out_rgb;
    logic                   r_out_flat;

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_load;
    t_op                    w_op;
    logic [HEIGHT_BITS-1:0] w_sample;
    logic [HEIGHT_BITS-1:0] w_clamped;
    logic [HEIGHT_BITS-1:0] w_diff;
    logic [HEIGHT_BITS+2:0] w_diff_x5;
    logic [NUM_W-1:0]       n_num;
    logic [HEIGHT_BITS:0]   n_range;
    logic                   w_ge;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    // A finished colour moves into the output register in this cycle.
    assign w_load        = (r_state == ST_FINISH) && w_out_free;
    assign w_op          = t_op'(s_axis_tuser);
    // Bits of the sample above the height width are simply dropped.
    assign w_sample      = s_axis_tdata[HEIGHT_BITS-1:0];

    always_comb begin
        // Clamp the sample into the scanned range before mapping.
        if (w_sample < r_lo) begin
            w_clamped = r_lo;
        end else if (w_sample > r_hi) begin
            w_clamped = r_hi;
        end else begin
            w_clamped = w_sample;
        end
        // Scale the offset by 1280 as (x * 5) << 8.
        w_diff    = r_h - r_lo;
        w_diff_x5 = {1'b0, w_diff, 2'b00} + {3'b000, w_diff};
        n_num     = {w_diff_x5, {T_BITS{1'b0}}};
        n_range   = {1'b0, r_hi} - {1'b0, r_lo} + {{HEIGHT_BITS{1'b0}}, 1'b1};
        // One restoring-division step: trial compare against the aligned divisor.
        w_ge      = (r_num >= r_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lo        <= '1;
            r_hi        <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (r_out_valid && m_axis_tready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        unique case (w_op)
                            OP_SCAN: begin
                                if (w_sample < r_lo) begin
                                    r_lo <= w_sample;
                                end
                                if (w_sample > r_hi) begin
                                    r_hi <= w_sample;
                                end
                            end
                            OP_CLEAR: begin
                                r_lo <= '1;
                                r_hi <= '0;
                            end
                            OP_MAP: begin
                                r_h    <= w_clamped;
                                // An empty or single-valued range maps to black.
                                r_flat <= (r_lo >= r_hi);
                                r_quot <= '0;
                                if (r_lo >= r_hi) begin
                                    r_state <= ST_FINISH;
                                end else begin
                                    r_state <= ST_SETUP;
                                end
                            end
                            default: begin
                                // The unused op code is dropped without effect.
                            end
                        endcase
                    end
                end
                ST_SETUP: begin
                    r_num   <= n_num;
                    r_range <= n_range;
                    r_den   <= {n_range, {(QUOT_BITS-1){1'b0}}};
                    r_step  <= '0;
                    r_state <= ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    if (w_ge) begin
                        r_num <= r_num - r_den;
                    end
                    r_den  <= r_den >> 1;
                    r_quot <= {r_quot[QUOT_BITS-2:0], w_ge};
                    r_step <= r_step + CNT_W'(1);
                    if (r_step == LAST_STEP) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    // Wait here while an earlier colour is still unclaimed.
                    if (w_load) begin
                        r_out_valid <= 1'b1;
                        r_out_flat  <= r_flat;
                        r_out_rgb   <= r_flat ? '0 : ramp_colour(r_quot);
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {r_out_rgb[3*CHAN_BITS-1:2*CHAN_BITS],
                              r_out_rgb[2*CHAN_BITS-1:CHAN_BITS],
                              r_out_rgb[CHAN_BITS-1:0]};
    assign m_axis_tuser[0] = r_out_flat;

    // A scan always leaves a non-empty range with minimum not above maximum.
    `HPC_ASSERT_NEXT(a_scan_orders_range,
        w_accept && (w_op == OP_SCAN), r_lo <= r_hi,
        "range minimum above maximum after a scan")
    // The divider leaves a remainder below the divisor once it completes.
    `HPC_ASSERT_NOW(a_remainder_bounded,
        (r_state == ST_FINISH) && !r_flat, r_num < {{(QUOT_BITS-1){1'b0}}, r_range},
        "divider remainder not below the range")
    // The quotient never exceeds the last ramp position.
    `HPC_ASSERT_NOW(a_quotient_bounded,
        (r_state == ST_FINISH) && !r_flat, r_quot < t_quot'(1280),
        "ramp position beyond the last segment")
    // A flat result is always black.
    `HPC_ASSERT_NOW(a_flat_is_black,
        m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 24'd0,
        "flat result carries a colour")

endmodule

FILE: test/heightmap_palette_colouriser_tb.sv
`timescale 1ns / 1ps

module heightmap_palette_colouriser_tb;
    import hpc_pkg::*;

    localparam int HEIGHT_BITS     = 16;
    localparam int RANDOM_REQUESTS = 1450;
    localparam int MAX_WAIT        = 18;
    // Allow well beyond the time of one map request once the queue is empty.
    localparam int DRAIN_CYCLES    = 40;
    // Worst case is roughly 1500 requests, each with its idle gap, busy time and stall.
    localparam int CYCLE_LIMIT     = 500000;
    localparam int REPORT_LINES    = 200;

    // Code 3 is left unused by the package; the block must ignore it.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Ramp points, point 0 in the lowest byte: black, blue, cyan, green, yellow, red.
    localparam logic [47:0] RAMP_RED   = {8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0};
    localparam logic [47:0] RAMP_GREEN = {8'd0,   8'd255, 8'd255, 8'd255, 8'd0,   8'd0};
    localparam logic [47:0] RAMP_BLUE  = {8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd0};

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       flat;
    } t_colour;

    // One row of the directed table; the colour is only used where typed is set.
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] sample;
        logic        typed;
        t_colour     want;
    } t_stim;

    localparam t_colour NO_COLOUR  = '{8'd0,   8'd0, 8'd0, 1'b0};
    localparam t_colour FLAT_BLACK = '{8'd0,   8'd0, 8'd0, 1'b1};
    localparam t_colour BLACK      = '{8'd0,   8'd0, 8'd0, 1'b0};
    localparam t_colour RED        = '{8'd255, 8'd0, 8'd0, 1'b0};
    localparam int DIRECTED_ROWS = 25;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [15:0] sample
    logic [1:0]  s_axis_tuser = '0;    // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [7:0] red, [15:8] green, [23:16] blue
    logic [0:0]  m_axis_tuser;         // [0] flat

    // Predictor state: the running range as the block should hold it.
    logic [15:0] lowest_seen = '1;
    logic [15:0] highest_seen = '0;

    // Colours owed by the block, oldest first.
    t_colour colour_due [$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int send_calm = 0;
    int sink_calm = 0;

    heightmap_palette_colouriser #(
        .HEIGHT_BITS(HEIGHT_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake must not leave the run going for ever.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
            $display("[%0t] %s", $time, what);
    endtask

    // Linear blend of two ramp points, rounded down as the block does.
    function automatic logic [7:0] blend(input int unsigned p1, input int unsigned p2,
                                         input int unsigned t);
        return 8'((p1 * (255 - t) + p2 * t) / 255);
    endfunction

    // Works out what one request does to the range and which colour, if any, it owes.
    function automatic void predict_colour(input logic [1:0] op, input logic [15:0] sample,
                                           output bit gives, output t_colour c);
        int unsigned h;
        int unsigned span;
        int unsigned q;
        int unsigned seg;
        int unsigned t;
        gives = 1'b0;
        c     = NO_COLOUR;
        case (op)
            OP_SCAN: begin
                if (sample < lowest_seen)
                    lowest_seen = sample;
                if (sample > highest_seen)
                    highest_seen = sample;
            end
            OP_CLEAR: begin
                lowest_seen  = '1;
                highest_seen = '0;
            end
            OP_MAP: begin
                gives = 1'b1;
                if (lowest_seen >= highest_seen) begin
                    // Nothing to spread the ramp over: black, marked flat.
                    c.flat = 1'b1;
                end else begin
                    h = sample;
                    if (h < lowest_seen)
                        h = lowest_seen;
                    if (h > highest_seen)
                        h = highest_seen;
                    span = highest_seen - lowest_seen + 1;
                    q    = ((h - lowest_seen) * 1280) / span;
                    seg  = q >> 8;
                    t    = q & 255;
                    if (seg > 4)
                        seg = 4;
                    c.red   = blend(RAMP_RED[seg*8 +: 8],   RAMP_RED[(seg+1)*8 +: 8],   t);
                    c.green = blend(RAMP_GREEN[seg*8 +: 8], RAMP_GREEN[(seg+1)*8 +: 8], t);
                    c.blue  = blend(RAMP_BLUE[seg*8 +: 8],  RAMP_BLUE[(seg+1)*8 +: 8],  t);
                end
            end
            default: ;
        endcase
    endfunction

    // Idle cycles before the next request on one side, with runs of back-to-back traffic.
    task automatic draw_wait(inout int calm_left, output int cycles);
        if (calm_left > 0) begin
            calm_left--;
            cycles = 0;
        end else if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(10, 40);
            cycles    = 0;
        end else begin
            cycles = $urandom_range(0, MAX_WAIT);
        end
    endtask

    // Presents one request, waits for it to be taken, then books the colour it owes.
    // The valid line is only lowered when a gap is drawn, so back-to-back requests
    // never see two assignments to it in one step.
    task automatic send_request(input logic [1:0] op, input logic [15:0] sample,
                                input logic typed, input t_colour want);
        int      gap;
        bit      gives;
        t_colour c;
        draw_wait(send_calm, gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= sample;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_colour(op, sample, gives, c);
        if (gives)
            colour_due.push_back(typed ? want : c);
    endtask

    // Heights for one random sequence: anywhere, in a narrow cluster, at the
    // extremes, or one bit away from a base value.
    function automatic logic [15:0] pick_height(input int style, input logic [15:0] base);
        logic [15:0] h;
        case (style)
            0:       h = 16'($urandom);
            1:       h = base + 16'($urandom_range(0, 15));
            2:       h = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default: h = base ^ (16'd1 << $urandom_range(0, 15));
        endcase
        return h;
    endfunction

    // Colour side: stalls at random, then compares each delivered colour
    // field by field against the oldest one owed.
    initial begin : colour_sink
        int      stall;
        t_colour got;
        t_colour want;
        forever begin
            draw_wait(sink_calm, stall);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && i_rst_n));
            got = '{m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                    m_axis_tuser[0]};
            if (colour_due.size() == 0) begin
                report($sformatf("colour %h/%h/%h flat %b with no request waiting",
                                 got.red, got.green, got.blue, got.flat));
            end else begin
                want = colour_due.pop_front();
                if (got.red !== want.red)
                    report($sformatf("red %h, wanted %h", got.red, want.red));
                if (got.green !== want.green)
                    report($sformatf("green %h, wanted %h", got.green, want.green));
                if (got.blue !== want.blue)
                    report($sformatf("blue %h, wanted %h", got.blue, want.blue));
                if (got.flat !== want.flat)
                    report($sformatf("flat %b, wanted %b", got.flat, want.flat));
            end
        end
    end

    initial begin : stimulus
        t_stim       directed [DIRECTED_ROWS];
        int          sent;
        int          style;
        int          count;
        logic [1:0]  op;
        logic [15:0] base;
        logic [15:0] sample;
        // Directed rows. Colours are typed in where they are obvious: an empty or
        // single-valued range, the bottom of any range and the top of the full range.
        directed = '{
            '{OP_MAP,    16'h0000, 1'b1, FLAT_BLACK},  // empty range straight after reset
            '{OP_UNUSED, 16'hFFFF, 1'b0, NO_COLOUR},   // unused code is ignored
            '{OP_SCAN,   16'h1234, 1'b0, NO_COLOUR},
            '{OP_MAP,    16'h1234, 1'b1, FLAT_BLACK},  // single-valued range
            '{OP_SCAN,   16'h0000, 1'b0, NO_COLOUR},
            '{OP_SCAN,   16'hFFFF, 1'b0, NO_COLOUR},
            '{OP_MAP,    16'h0000, 1'b1, BLACK},       // bottom of the full range
            '{OP_MAP,    16'hFFFF, 1'b1, RED},         // top of the full range
            '{OP_MAP,    16'h8000, 1'b0, NO_COLOUR},
            '{OP_MAP,    16'h3333, 1'b0, NO_COLOUR},
            '{OP_MAP,    16'h5555, 1'b0, NO_COLOUR},
            '{OP_MAP,    16'hAAAA, 1'b0, NO_COLOUR},
            '{OP_UNUSED, 16'h0005, 1'b0, NO_COLOUR},   // must not touch the range
            '{OP_MAP,    16'h0000, 1'b1, BLACK},
            '{OP_CLEAR,  16'hFFFF, 1'b0, NO_COLOUR},
            '{OP_MAP,    16'h0000, 1'b1, FLAT_BLACK},  // cleared back to empty
            '{OP_SCAN,   16'd100,  1'b0, NO_COLOUR},
            '{OP_SCAN,   16'd50,   1'b0, NO_COLOUR},
            '{OP_MAP,    16'h0000, 1'b1, BLACK},       // clamped up to the minimum
            '{OP_MAP,    16'hFFFF, 1'b0, NO_COLOUR},   // clamped down to the maximum
            '{OP_MAP,    16'd75,   1'b0, NO_COLOUR},
            '{OP_CLEAR,  16'h0000, 1'b0, NO_COLOUR},
            '{OP_SCAN,   16'd7,    1'b0, NO_COLOUR},
            '{OP_SCAN,   16'd8,    1'b0, NO_COLOUR},
            '{OP_MAP,    16'd8,    1'b0, NO_COLOUR}    // smallest range with a spread
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_request(directed[i].op, directed[i].sample, directed[i].typed,
                         directed[i].want);

        // Random part: mostly a clear, a handful of scans and then several maps
        // into that range, with the odd stray request in between. Ignored
        // requests do not count towards the total.
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            if ($urandom_range(0, 9) == 0) begin
                op     = 2'($urandom_range(0, 3));
                sample = 16'($urandom);
                send_request(op, sample, 1'b0, NO_COLOUR);
                if (op != OP_UNUSED)
                    sent++;
            end else begin
                style = $urandom_range(0, 3);
                base  = 16'($urandom);
                if ($urandom_range(0, 3) != 0) begin
                    sample = 16'($urandom);
                    send_request(OP_CLEAR, sample, 1'b0, NO_COLOUR);
                    sent++;
                end
                count = $urandom_range(1, 5);
                repeat (count) begin
                    send_request(OP_SCAN, pick_height(style, base), 1'b0, NO_COLOUR);
                    sent++;
                end
                count = $urandom_range(1, 8);
                repeat (count) begin
                    // Now and then a height from anywhere, to exercise clamping.
                    if ($urandom_range(0, 3) == 0)
                        sample = 16'($urandom);
                    else
                        sample = pick_height(style, base);
                    send_request(OP_MAP, sample, 1'b0, NO_COLOUR);
                    sent++;
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // Let every owed colour arrive, then watch a while for anything extra.
        while (colour_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
